### rtl/core/ffipw_pkg.sv
// Package for the fuel film injector pulse width block: widths, constants, types.
// No dependencies; used by fuel_film_injector_pulse_width_top.
package ffipw_pkg;
  localparam int NumInjectors = 8;
  localparam int InjW = 3;
  localparam int DivW = 64;
  localparam int CntW = 7;
  localparam logic [31:0] EvapScale = 32'd50000;
  localparam logic [31:0] PerMille = 32'd1000;
  localparam logic [31:0] PwNumerator = 32'd10000000;
  localparam logic [31:0] MaxPwMargin = 32'd500;
  localparam logic [31:0] PuddleMax = 32'h7fff_ffff;
  // ceil(2^36 / 1000): floor(x * RecipMille >> RecipShift) == x / 1000 for x < 2^26
  localparam logic [31:0] RecipMille = 32'd68719477;
  localparam int RecipShift = 36;

  localparam logic [0:0] RegFuelCorr = 1'b0;
  localparam logic [0:0] RegMinPulse = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_EVAP, ST_MUL_TAU, ST_DIV_EVAP, ST_MUL_ADD, ST_RCP_ADD,
    ST_UPD, ST_DIV_ENR, ST_MUL_Q, ST_DIV_Q, ST_DIV_PW, ST_CLAMP, ST_OUT
  } state_t;
endpackage

### rtl/core/fuel_film_injector_pulse_width_top.sv
// Fuel film injector pulse width top level: X-tau puddle model plus pulse width.
// Depends on ffipw_pkg; one shared 32x32 multiplier and one shared radix-2 divider.
// The number of divisions depends on the item: four 64-bit divisions when tau, required
// fuel and the flow quotient are all nonzero, three when the flow quotient is zero,
// none when no division is needed. The input stalls until the result transfers, so a
// new item is not taken before the last result has gone. Reset (synchronous, rst_n low)
// clears puddles, sets fuel_correction to 1 and min_pulse to 500, and returns to idle.
module fuel_film_injector_pulse_width_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_required_fuel,
  input  logic [2:0]  in_injector,
  input  logic [19:0] in_rev_time,
  input  logic [15:0] in_tau,
  input  logic [9:0]  in_x_fraction,
  input  logic [15:0] in_flow_rate,
  input  logic [15:0] in_dead_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] out_pulse_width,
  output logic [2:0]  out_injector_out,
  output logic signed [15:0] out_film_enrich,
  output logic signed [31:0] out_film_fuel,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  ffipw_pkg::state_t state_r, state_nxt;

  logic [15:0] fuel_corr_r, min_pulse_r;
  logic [31:0] puddle_r [ffipw_pkg::NumInjectors];

  // captured item
  logic [15:0] req_r, flow_r, dead_r, tau_r;
  logic [2:0]  inj_r;
  logic [19:0] rev_r;
  logic [9:0]  xf_r;

  // working values
  logic [63:0] prod_r;   // result of the shared multiplier, dividend staging
  logic [31:0] pud_r;
  logic [35:0] evap_r;   // evaporation may exceed the puddle when rev_time > tau*50000
  logic [31:0] added_r;
  logic signed [37:0] fuel_r;
  logic signed [15:0] enrich_r;
  logic [20:0] pw_r;
  logic        upd_en;

  // shared divider
  logic [63:0] dq_r, dr_r;   // quotient/dividend shift reg, remainder
  logic [63:0] ddiv_r;
  logic [ffipw_pkg::CntW-1:0] dcnt_r;
  logic        dbusy_r;
  logic        dstart;
  logic [63:0] dstart_num, dstart_den;
  logic [64:0] dtrial;
  logic [63:0] drem_sh;

  logic        inj_valid;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign inj_valid = ({1'b0, inj_r} < 4'(ffipw_pkg::NumInjectors));

  always_comb begin
    unique case (cfg_paddr[2])
      ffipw_pkg::RegFuelCorr: cfg_prdata = {16'd0, fuel_corr_r};
      default:                cfg_prdata = {16'd0, min_pulse_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fuel_corr_r <= 16'd1;
      min_pulse_r <= 16'd500;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        ffipw_pkg::RegFuelCorr: fuel_corr_r <= cfg_pwdata[15:0];
        default:                min_pulse_r <= cfg_pwdata[15:0];
      endcase
    end
  end

  assign in_stall = (state_r != ffipw_pkg::ST_IDLE);
  assign out_valid = (state_r == ffipw_pkg::ST_OUT);

  // Restoring divider, one quotient bit per cycle.
  assign drem_sh = {dr_r[62:0], dq_r[63]};
  assign dtrial  = {1'b0, drem_sh} - {1'b0, ddiv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      dcnt_r  <= '0;
    end else if (dstart) begin
      dbusy_r <= 1'b1;
      dcnt_r  <= '0;
    end else if (dbusy_r) begin
      dcnt_r <= dcnt_r + 1'b1;
      if (dcnt_r == ffipw_pkg::CntW'(ffipw_pkg::DivW - 1)) dbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dstart) begin
      dq_r   <= dstart_num;
      dr_r   <= '0;
      ddiv_r <= dstart_den;
    end else if (dbusy_r) begin
      if (!dtrial[64]) begin
        dr_r <= dtrial[63:0];
        dq_r <= {dq_r[62:0], 1'b1};
      end else begin
        dr_r <= drem_sh;
        dq_r <= {dq_r[62:0], 1'b0};
      end
    end
  end

  logic ddone;
  assign ddone = dbusy_r && (dcnt_r == ffipw_pkg::CntW'(ffipw_pkg::DivW - 1));
  // quotient after the final step
  logic [63:0] dquot;
  assign dquot = {dq_r[62:0], !dtrial[64]};

  // shared multiplier: 32x32
  logic [31:0] ma, mb;
  logic [63:0] mprod;
  logic [63:0] rcp_sh;
  assign mprod = ma * mb;
  // divide by 1000 through the reciprocal product
  assign rcp_sh = mprod >> ffipw_pkg::RecipShift;

  // derived combinational values
  logic signed [37:0] newpud_s;
  logic [31:0] newpud;
  logic signed [31:0] fsat;
  logic [21:0] maxpw;
  logic [21:0] rev2;
  logic [38:0] enr_abs;
  logic [63:0] enr_num_abs;
  logic        enr_neg;
  logic signed [38:0] diff_s;

  assign newpud_s = $signed({6'b0, pud_r}) - $signed({2'b0, evap_r})
                  + $signed({6'b0, added_r});
  assign newpud = newpud_s[37] ? 32'd0 :
                  (newpud_s > $signed({6'b0, ffipw_pkg::PuddleMax})) ?
                  ffipw_pkg::PuddleMax : newpud_s[31:0];
  assign fsat = (fuel_r > 38'sh0_7fff_ffff) ? 32'sh7fff_ffff :
                (fuel_r < -38'sh0_8000_0000) ? 32'sh8000_0000 : fuel_r[31:0];
  assign rev2 = {1'b0, rev_r, 1'b0};
  assign maxpw = (rev2 > 22'(ffipw_pkg::MaxPwMargin)) ?
                 rev2 - 22'(ffipw_pkg::MaxPwMargin) : 22'd0;
  assign diff_s = 39'(fuel_r) - $signed({23'd0, req_r});
  assign enr_neg = diff_s[38];
  assign enr_abs = enr_neg ? $unsigned(-diff_s) : $unsigned(diff_s);
  // times 1000 as 1024 - 16 - 8
  assign enr_num_abs = ({25'd0, enr_abs} << 10) - ({25'd0, enr_abs} << 4)
                     - ({25'd0, enr_abs} << 3);

  always_comb begin
    state_nxt = state_r;
    dstart = 1'b0;
    dstart_num = prod_r;
    dstart_den = 64'd1;
    ma = {16'd0, req_r};
    mb = {22'd0, xf_r};
    upd_en = 1'b0;
    unique case (state_r)
      ffipw_pkg::ST_IDLE:     if (in_valid) state_nxt = ffipw_pkg::ST_MUL_EVAP;
      ffipw_pkg::ST_MUL_EVAP: begin
        ma = pud_r; mb = {12'd0, rev_r};
        state_nxt = ffipw_pkg::ST_MUL_TAU;
      end
      ffipw_pkg::ST_MUL_TAU: begin
        ma = {16'd0, tau_r}; mb = ffipw_pkg::EvapScale;
        if (tau_r == 16'd0) state_nxt = ffipw_pkg::ST_MUL_ADD;
        else begin
          dstart = 1'b1;
          dstart_den = mprod;
          state_nxt = ffipw_pkg::ST_DIV_EVAP;
        end
      end
      ffipw_pkg::ST_DIV_EVAP: if (ddone) state_nxt = ffipw_pkg::ST_MUL_ADD;
      ffipw_pkg::ST_MUL_ADD: begin
        ma = {16'd0, req_r}; mb = {22'd0, xf_r};
        state_nxt = ffipw_pkg::ST_RCP_ADD;
      end
      ffipw_pkg::ST_RCP_ADD: begin
        ma = prod_r[31:0]; mb = ffipw_pkg::RecipMille;
        state_nxt = ffipw_pkg::ST_UPD;
      end
      ffipw_pkg::ST_UPD: begin
        upd_en = inj_valid;
        dstart = (req_r != 16'd0);
        dstart_num = enr_num_abs; dstart_den = {48'd0, req_r};
        state_nxt = ffipw_pkg::ST_DIV_ENR;
      end
      ffipw_pkg::ST_DIV_ENR: if (!dbusy_r) state_nxt = ffipw_pkg::ST_MUL_Q;
      ffipw_pkg::ST_MUL_Q: begin
        ma = {16'd0, flow_r}; mb = {16'd0, fuel_corr_r};
        if (fsat <= 0) state_nxt = ffipw_pkg::ST_CLAMP;
        else begin
          dstart = 1'b1; dstart_num = mprod; dstart_den = {32'd0, fsat};
          state_nxt = ffipw_pkg::ST_DIV_Q;
        end
      end
      ffipw_pkg::ST_DIV_Q: if (ddone) begin
        if (dquot == 64'd0) state_nxt = ffipw_pkg::ST_CLAMP;
        else begin
          // chain the pulse-width division straight onto the quotient
          dstart = 1'b1;
          dstart_num = 64'(ffipw_pkg::PwNumerator);
          dstart_den = dquot;
          state_nxt = ffipw_pkg::ST_DIV_PW;
        end
      end
      ffipw_pkg::ST_DIV_PW: if (ddone) state_nxt = ffipw_pkg::ST_CLAMP;
      ffipw_pkg::ST_CLAMP: state_nxt = ffipw_pkg::ST_OUT;
      ffipw_pkg::ST_OUT: if (!out_stall) state_nxt = ffipw_pkg::ST_IDLE;
      default: state_nxt = ffipw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ffipw_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ffipw_pkg::NumInjectors; i++) puddle_r[i] <= '0;
    end else begin
      if (upd_en) puddle_r[inj_r] <= newpud;
    end
  end

  // datapath registers
  logic [63:0] pwq;
  always_comb begin
    pwq = dquot + {48'd0, dead_r};
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ffipw_pkg::ST_IDLE: if (in_valid) begin
        req_r <= in_required_fuel; inj_r <= in_injector; rev_r <= in_rev_time;
        tau_r <= in_tau; xf_r <= in_x_fraction; flow_r <= in_flow_rate;
        dead_r <= in_dead_time;
        pud_r <= ({1'b0, in_injector} < 4'(ffipw_pkg::NumInjectors)) ?
                 puddle_r[in_injector] : 32'd0;
      end
      ffipw_pkg::ST_MUL_EVAP: begin
        prod_r <= mprod;
        evap_r <= {4'd0, pud_r};
      end
      ffipw_pkg::ST_DIV_EVAP: if (ddone) evap_r <= dquot[35:0];
      ffipw_pkg::ST_MUL_ADD: prod_r <= mprod;
      ffipw_pkg::ST_RCP_ADD: begin
        added_r <= {15'd0, rcp_sh[16:0]};
        fuel_r <= $signed({22'd0, req_r}) - $signed({2'b0, evap_r})
                + $signed({21'd0, rcp_sh[16:0]});
      end
      ffipw_pkg::ST_UPD: enrich_r <= 16'sd0;
      ffipw_pkg::ST_DIV_ENR: if (ddone) begin
        if (enr_neg) enrich_r <= (dquot > 64'd32768) ? -16'sd32768 : 16'(-dquot[16:0]);
        else enrich_r <= (dquot > 64'd32767) ? 16'sd32767 : dquot[15:0];
      end
      ffipw_pkg::ST_MUL_Q: if (fsat <= 0) pw_r <= 21'(min_pulse_r);
      ffipw_pkg::ST_DIV_Q: if (ddone) begin
        if (dquot == 64'd0) pw_r <= maxpw[20:0];
      end
      ffipw_pkg::ST_DIV_PW: if (ddone) begin
        pw_r <= (pwq > 64'h1f_ffff) ? 21'h1f_ffff : pwq[20:0];
      end
      ffipw_pkg::ST_CLAMP: begin
        if ({1'b0, pw_r} < 22'(min_pulse_r)) begin
          pw_r <= (22'(min_pulse_r) > maxpw) ? maxpw[20:0] : 21'(min_pulse_r);
        end else if ({1'b0, pw_r} > maxpw) pw_r <= maxpw[20:0];
      end
      default: ;
    endcase
  end

  assign out_pulse_width  = pw_r;
  assign out_injector_out = inj_r;
  assign out_film_enrich  = enrich_r;
  assign out_film_fuel    = fsat;

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ffipw_pkg::ST_IDLE |-> !dbusy_r) else $error("divider busy in idle");
`endif
endmodule
